[sv/ukp_pkg.sv]
// Shared types and constants for the unbounded knapsack solver.
`timescale 1ns / 1ps

package ukp_pkg;

	localparam int WEIGHT_W   = 10;
	localparam int PROFIT_W   = 16;
	localparam int CAP_W      = 10;
	localparam int TABLE_W    = 27;
	localparam int CAND_W     = TABLE_W + 1;
	localparam int BEST_W     = 26;
	localparam int CHOSEN_W   = 7;
	localparam int ITEM_W     = WEIGHT_W + PROFIT_W;

	localparam int MAX_CAPACITY_DEF = 1024;
	localparam int MAX_ITEMS_DEF    = 64;

	typedef logic [CAP_W-1:0]    cap_t;
	typedef logic [CHOSEN_W-1:0] chosen_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] item_weight;
		logic [PROFIT_W-1:0] item_profit;
		logic                last_item;
	} item_t;

	typedef struct packed {
		logic [BEST_W-1:0] best_profit;
		chosen_t           chosen_item;
	} result_t;

	typedef struct packed {
		logic clear;
		logic issue;
	} cu_ctl_t;

endpackage

[sv/ukp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ukp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/ukp_cand_unit.sv]
// Candidate unit: fit check, table address, profit add and best compare.
`timescale 1ns / 1ps

module ukp_cand_unit #(
	parameter int MAX_CAPACITY = ukp_pkg::MAX_CAPACITY_DEF,
	parameter int MAX_ITEMS    = ukp_pkg::MAX_ITEMS_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  ukp_pkg::cu_ctl_t                             ctl,
	input  logic [(MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1)-1:0] idx,
	input  logic [$clog2(MAX_CAPACITY)-1:0]              cap_idx,
	input  logic [ukp_pkg::ITEM_W-1:0]                   item_rdata,
	input  logic [ukp_pkg::TABLE_W-1:0]                  tbl_rdata,
	output logic [$clog2(MAX_CAPACITY)-1:0]              tbl_raddr,
	output logic                                         busy,
	output logic [ukp_pkg::CAND_W-1:0]                   best,
	output logic [$clog2(MAX_ITEMS + 1)-1:0]             pick
);

	localparam int TAW  = $clog2(MAX_CAPACITY);
	localparam int IAW  = MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1;
	localparam int ICW  = $clog2(MAX_ITEMS + 1);
	localparam int WCMP = TAW > ukp_pkg::WEIGHT_W ? TAW : ukp_pkg::WEIGHT_W;

	logic                          v_s1;
	logic [IAW-1:0]                idx_s1;
	logic                          v_s2;
	logic [IAW-1:0]                idx_s2;
	logic [ukp_pkg::PROFIT_W-1:0]  profit_s2;
	logic                          zero_s2;
	logic [ukp_pkg::CAND_W-1:0]    best_q;
	logic [ICW-1:0]                pick_q;

	logic [ukp_pkg::WEIGHT_W-1:0]  wt;
	logic [ukp_pkg::PROFIT_W-1:0]  pr;
	logic                          fits;
	logic [ukp_pkg::CAND_W-1:0]    cand;

	assign wt   = item_rdata[ukp_pkg::PROFIT_W +: ukp_pkg::WEIGHT_W];
	assign pr   = item_rdata[ukp_pkg::PROFIT_W-1:0];
	assign fits = (wt != '0) && (WCMP'(wt) <= WCMP'(cap_idx));
	assign tbl_raddr = TAW'(WCMP'(cap_idx) - WCMP'(wt));

	assign cand = ukp_pkg::CAND_W'(profit_s2)
		+ (zero_s2 ? '0 : ukp_pkg::CAND_W'(tbl_rdata));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			best_q <= '0;
			pick_q <= ICW'(MAX_ITEMS);
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1 && fits;
			if (ctl.clear) begin
				best_q <= '0;
				pick_q <= ICW'(MAX_ITEMS);
			end else if (v_s2 && (cand > best_q)) begin
				best_q <= cand;
				pick_q <= ICW'(idx_s2);
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1    <= idx;
		idx_s2    <= idx_s1;
		profit_s2 <= pr;
		zero_s2   <= (tbl_raddr == '0);
	end

	assign busy = v_s1 | v_s2;
	assign best = best_q;
	assign pick = pick_q;

endmodule

[sv/unbounded_knapsack_solver_core.sv]
// Top level of the unbounded knapsack solver: item loading, fill sequencer, result register.
`timescale 1ns / 1ps

// Items load one per cycle into the item store while the solver is idle. The item marked last starts
// the fill: for each capacity from 1 to the configured capacity (saturated to MAX_CAPACITY-1), every
// stored item is read in turn and evaluated by one shared add-and-compare unit, one item read per
// cycle, through its pipeline registers, before the table entry is written. The result transaction
// waits while the result side stalls; the item channel is stalled throughout. Ties keep the earlier
// item. The best-profit table is never cleared: entry zero always reads as zero, and every other
// entry is written before it is read. The item store is emptied once the result is registered.

module unbounded_knapsack_solver_core #(
	parameter int MAX_CAPACITY = ukp_pkg::MAX_CAPACITY_DEF,
	parameter int MAX_ITEMS    = ukp_pkg::MAX_ITEMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  ukp_pkg::cap_t     cfg_wr_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  ukp_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output ukp_pkg::result_t  result
);

	localparam int TAW   = $clog2(MAX_CAPACITY);
	localparam int IAW   = MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1;
	localparam int ICW   = $clog2(MAX_ITEMS + 1);
	localparam int CMP_W = TAW > ukp_pkg::CAP_W ? TAW : ukp_pkg::CAP_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_ISSUE  = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	logic [1:0]              state_q;
	ukp_pkg::cap_t           capacity_q;
	logic [ICW-1:0]          count_q;
	logic [ICW-1:0]          n_q;
	logic [TAW-1:0]          cap_q;
	logic [TAW-1:0]          i_q;
	logic [IAW-1:0]          j_q;
	logic                    result_valid_q;
	ukp_pkg::result_t        result_q;

	logic                    accept;
	logic                    store_we;
	logic [ICW-1:0]          count_next;
	logic [TAW-1:0]          cap_eff;
	logic                    issue_last;
	logic                    tbl_we;
	logic                    out_free;
	ukp_pkg::cu_ctl_t        cu_ctl;

	logic [ukp_pkg::ITEM_W-1:0]  item_rdata;
	logic [ukp_pkg::TABLE_W-1:0] tbl_rdata;
	logic [TAW-1:0]              tbl_raddr;
	logic                        cu_busy;
	logic [ukp_pkg::CAND_W-1:0]  cu_best;
	logic [ICW-1:0]              cu_pick;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign store_we   = accept && (count_q < ICW'(MAX_ITEMS));
	assign count_next = store_we ? ICW'(count_q + 1'b1) : count_q;
	assign cap_eff    = (CMP_W'(capacity_q) > CMP_W'(MAX_CAPACITY - 1))
		? TAW'(MAX_CAPACITY - 1) : TAW'(capacity_q);
	assign issue_last = (ICW'(j_q) + ICW'(1)) == n_q;
	assign tbl_we     = (state_q == S_DRAIN) && !cu_busy;
	assign out_free   = !result_valid_q || !result_stall;

	assign cu_ctl.issue = (state_q == S_ISSUE);
	assign cu_ctl.clear = (accept && item.last_item) || (tbl_we && (i_q != cap_q));

	ukp_ram #(
		.WIDTH (ukp_pkg::ITEM_W),
		.DEPTH (MAX_ITEMS)
	) u_item_ram (
		.clk   (clk),
		.we    (store_we),
		.waddr (IAW'(count_q)),
		.wdata ({item.item_weight, item.item_profit}),
		.raddr (j_q),
		.rdata (item_rdata)
	);

	ukp_ram #(
		.WIDTH (ukp_pkg::TABLE_W),
		.DEPTH (MAX_CAPACITY)
	) u_table_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (i_q),
		.wdata (cu_best[ukp_pkg::TABLE_W-1:0]),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	ukp_cand_unit #(
		.MAX_CAPACITY (MAX_CAPACITY),
		.MAX_ITEMS    (MAX_ITEMS)
	) u_cand_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (cu_ctl),
		.idx        (j_q),
		.cap_idx    (i_q),
		.item_rdata (item_rdata),
		.tbl_rdata  (tbl_rdata),
		.tbl_raddr  (tbl_raddr),
		.busy       (cu_busy),
		.best       (cu_best),
		.pick       (cu_pick)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			capacity_q     <= '0;
			count_q        <= '0;
			n_q            <= '0;
			cap_q          <= '0;
			i_q            <= '0;
			j_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						count_q <= count_next;
						if (item.last_item) begin
							n_q   <= count_next;
							cap_q <= cap_eff;
							i_q   <= TAW'(1);
							j_q   <= '0;
							state_q <= (cap_eff == '0) ? S_FINISH : S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					j_q <= IAW'(j_q + 1'b1);
					if (issue_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!cu_busy) begin
						if (i_q == cap_q) begin
							state_q <= S_FINISH;
						end else begin
							i_q     <= TAW'(i_q + 1'b1);
							j_q     <= '0;
							state_q <= S_ISSUE;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						count_q        <= '0;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FINISH) && out_free) begin
			result_q.best_profit <= cu_best[ukp_pkg::BEST_W-1:0];
			result_q.chosen_item <= ukp_pkg::chosen_t'(cu_pick);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef NO_ASSERTIONS
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_FINISH))
		else $error("result transaction raised outside finish");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ISSUE) |-> (ICW'(j_q) < n_q))
		else $error("item read beyond stored count");

	a_entry_zero_kept: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> (i_q != '0) && (i_q <= cap_q))
		else $error("table write outside capacity range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ICW'(MAX_ITEMS))
		else $error("item count above store depth");
`endif

endmodule

[dv/unbounded_knapsack_solver_core_checker.sv]
// Checker for the unbounded knapsack solver: predicts each result and compares it field by field.
`timescale 1ns / 1ps

module unbounded_knapsack_solver_core_checker import ukp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr_en,
	input  cap_t    cfg_wr_data,
	input  logic    item_valid,
	input  logic    item_stall,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_stall,
	input  result_t result,
	output int      fail_count,
	output int      pending_results
);

	localparam chosen_t NO_ITEM = chosen_t'(MAX_ITEMS_DEF);

	logic [WEIGHT_W-1:0] set_weight [MAX_ITEMS_DEF];
	logic [PROFIT_W-1:0] set_profit [MAX_ITEMS_DEF];
	int                  set_count;
	cap_t                cap_shadow;
	result_t             expected_results [$];

	function automatic result_t solve_knapsack(input cap_t cap);
		logic [TABLE_W-1:0] best_at [MAX_CAPACITY_DEF];
		logic [CAND_W-1:0]  cand;
		logic [CAND_W-1:0]  top;
		chosen_t            pick;
		chosen_t            final_pick;
		result_t            r;
		best_at[0] = '0;
		final_pick = NO_ITEM;
		for (int i = 1; i <= int'(cap); i++) begin
			top = '0;
			pick = NO_ITEM;
			for (int j = 0; j < set_count; j++) begin
				if (set_weight[j] != 0 && int'(set_weight[j]) <= i) begin
					cand = CAND_W'(set_profit[j]) + CAND_W'(best_at[i - int'(set_weight[j])]);
					if (cand > top) begin
						top = cand;
						pick = chosen_t'(j);
					end
				end
			end
			best_at[i] = top[TABLE_W-1:0];
			if (i == int'(cap))
				final_pick = pick;
		end
		r.best_profit = best_at[cap][BEST_W-1:0];
		r.chosen_item = final_pick;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t knapsack checker: %s", $time, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			set_count = 0;
			cap_shadow = '0;
			fail_count = 0;
			expected_results.delete();
			pending_results <= 0;
		end else begin
			if (cfg_wr_en)
				cap_shadow = cfg_wr_data;
			if (item_valid && !item_stall) begin
				// drop items that arrive with the store full
				if (set_count < MAX_ITEMS_DEF) begin
					set_weight[set_count] = item.item_weight;
					set_profit[set_count] = item.item_profit;
					set_count++;
				end
				if (item.last_item) begin
					expected_results.push_back(solve_knapsack(cap_shadow));
					set_count = 0;
				end
			end
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("result transaction with nothing expected: %0d / %0d",
						result.best_profit, result.chosen_item));
				end else begin
					want = expected_results.pop_front();
					if (result.best_profit !== want.best_profit)
						report_mismatch($sformatf("best_profit %0d, expected %0d",
							result.best_profit, want.best_profit));
					if (result.chosen_item !== want.chosen_item)
						report_mismatch($sformatf("chosen_item %0d, expected %0d",
							result.chosen_item, want.chosen_item));
				end
			end
			pending_results <= expected_results.size();
		end
	end

endmodule

[dv/unbounded_knapsack_solver_core_test.sv]
// Testbench top for the unbounded knapsack solver: stimulus, stalls, watchdog and verdict.
`timescale 1ns / 1ps

module unbounded_knapsack_solver_core_test;
	import ukp_pkg::*;

	localparam int QUIET_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int BIG_CAP      = 48;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    cfg_wr_en;
	cap_t    cfg_wr_data;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	int      fail_count;
	int      pending_results;
	logic    steady = 1'b0;
	int      quiet_cycles = 0;

	always #5 clk = ~clk;

	unbounded_knapsack_solver_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	unbounded_knapsack_solver_core_checker knapsack_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.result          (result),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	always @(posedge clk) begin
		result_stall <= !steady && ($urandom_range(0, 99) < 30);
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_wr_en)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[unbounded_knapsack_solver_core] ERROR");
			$finish;
		end
	end

	task automatic send_item(input logic [WEIGHT_W-1:0] w, input logic [PROFIT_W-1:0] p,
		input logic last);
		item_t it;
		it.item_weight = w;
		it.item_profit = p;
		it.last_item = last;
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		if (!steady && $urandom_range(0, 99) < 30) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	endtask

	task automatic set_capacity(input cap_t v);
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_set(input int n, input int cap, input logic closed);
		logic [WEIGHT_W-1:0] w;
		logic [PROFIT_W-1:0] p;
		int                  r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				w = '0;
			else if (r < 13)
				w = WEIGHT_W'($urandom_range(0, 1023));
			else
				w = WEIGHT_W'($urandom_range(1, (cap < 1) ? 1 : cap));
			if ($urandom_range(0, 99) < 20)
				p = PROFIT_W'($urandom_range(0, 7));
			else
				p = PROFIT_W'($urandom_range(0, 65535));
			send_item(w, p, closed && (k == n - 1));
		end
	endtask

	initial begin : stimulus
		int stored;
		int cap_v;
		int sets;
		int n;
		int r;
		logic big;
		logic closed;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		item_valid = 1'b0;
		item = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero capacity
		set_capacity(cap_t'(0));
		send_item(10'd5, 16'd100, 1'b1);
		// full capacity, extreme weights and profits
		set_capacity(cap_t'(1023));
		send_item(10'd1023, 16'd65535, 1'b0);
		send_item(10'd1, 16'd65535, 1'b1);
		// zero weight, item too heavy, zero profit
		set_capacity(cap_t'(10));
		send_item(10'd0, 16'd500, 1'b0);
		send_item(10'd11, 16'd9, 1'b0);
		send_item(10'd3, 16'd0, 1'b1);
		// ties keep the earliest item
		send_item(10'd2, 16'd10, 1'b0);
		send_item(10'd2, 16'd10, 1'b1);
		send_item(10'd1, 16'd1, 1'b0);
		send_item(10'd2, 16'd2, 1'b1);
		// nothing fits
		send_item(10'd20, 16'd7, 1'b1);
		set_capacity(cap_t'(1));
		send_item(10'd1, 16'd1234, 1'b1);
		send_item(10'd1023, 16'd65535, 1'b1);

		stored = 0;
		while (stored < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				cap_v = 0;
			else if (r < 9)
				cap_v = 1023;
			else if (r < 15)
				cap_v = $urandom_range(0, 1023);
			else
				cap_v = $urandom_range(1, BIG_CAP);
			big = cap_v > BIG_CAP;
			set_capacity(cap_t'(cap_v));
			sets = $urandom_range(1, 6);
			for (int s = 0; s < sets; s++) begin
				if (!big && $urandom_range(0, 99) < 4)
					n = $urandom_range(MAX_ITEMS_DEF, MAX_ITEMS_DEF + 6);
				else
					n = big ? $urandom_range(1, 3) : $urandom_range(1, 8);
				closed = (s == sets - 1) || big || ($urandom_range(0, 99) >= 8);
				steady = (stored >= 500) && (stored < 700);
				send_set(n, cap_v, closed);
				stored += (n > MAX_ITEMS_DEF) ? MAX_ITEMS_DEF : n;
			end
		end
		steady = 1'b0;

		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("[unbounded_knapsack_solver_core] OK");
		else
			$display("[unbounded_knapsack_solver_core] ERROR");
		$finish;
	end

endmodule
